// ===== sv/pidfl_pkg.sv =====
// Shared constants, codes and types for the identifier allocator.
package pidfl_pkg;

  localparam int MaxIds = 32;
  localparam int SlotW  = $clog2(MaxIds);
  localparam int IdW    = 6;
  localparam int FuncW  = 2;
  localparam int StatW  = 2;
  localparam int CountW = 6;

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [IdW-1:0]   id_t;

  typedef enum logic [FuncW-1:0] {
    FuncAlloc   = 2'd0,
    FuncRelease = 2'd1,
    FuncQuery   = 2'd2,
    FuncNop     = 2'd3
  } func_t;

  typedef enum logic [StatW-1:0] {
    StatOk         = 2'd0,
    StatNoneFree   = 2'd1,
    StatBadRelease = 2'd2
  } status_t;

  typedef struct packed {
    logic  rd_en;
    slot_t rd_addr;
    logic  wr_en;
    slot_t wr_addr;
    id_t   wr_data;
  } queue_req_t;

  function automatic slot_t next_slot(slot_t slot);
    return (slot == slot_t'(MaxIds - 1)) ? '0 : slot + slot_t'(1);
  endfunction

endpackage

// ===== sv/pidfl_free_queue.sv =====
// Free identifier queue memory, with per-slot written flags standing in for its reset contents.
module pidfl_free_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  pidfl_pkg::queue_req_t req,
  output pidfl_pkg::id_t        rd_data
);
  import pidfl_pkg::*;

  id_t             mem [MaxIds];
  logic [MaxIds-1:0] written;
  id_t             rd_word;
  logic            rd_written;
  slot_t           rd_slot;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_word <= mem[req.rd_addr];
      rd_slot <= req.rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_written <= written[req.rd_addr];
      end
    end
  end

  // A slot never written still holds its reset identifier, the slot number plus one.
  assign rd_data = rd_written ? rd_word : id_t'(rd_slot) + id_t'(1);

endmodule

// ===== sv/pid_free_list_allocator.sv =====
// Top level of the identifier allocator: request sequencing, taken marks and result register.
//
//  Channel  Valid      Stall      Words carried
//  in       in_valid   in_stall   func, proc_id
//  out      out_valid  out_stall  granted_id, status, is_taken, in_use_count
//
// Each request is handled in two steps: in SIdle the free queue head slot is read from memory,
// and in SExec the marks, pointers and count are updated and the result register is loaded.
// A new request is taken while an earlier result waits in the result register.
// Reset is synchronous; the queue needs no clearing pass and the block is ready at once.
// A stalled result holds the following request in SExec until it is taken.
module pid_free_list_allocator (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            func,
  input  logic [5:0]            proc_id,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [5:0]            granted_id,
  output logic [1:0]            status,
  output logic                  is_taken,
  output logic [5:0]            in_use_count
);
  import pidfl_pkg::*;

  typedef enum logic {
    SIdle,
    SExec
  } state_t;

  state_t            state;
  logic [FuncW-1:0]  func_q;
  id_t               pid_q;
  slot_t             head;
  slot_t             tail;
  logic [MaxIds-1:0] marks;
  logic [CountW-1:0] used_count;
  queue_req_t        qreq;
  id_t               head_id;

  logic              accept;
  logic              exec_go;
  logic              pid_in_range;
  slot_t             pid_slot;
  logic              pid_taken;
  logic              do_alloc;
  logic              do_release;
  logic              alloc_full;
  logic              head_in_range;
  slot_t             head_id_slot;
  status_t           stat_next;
  id_t               granted_next;
  logic              taken_next;

  assign in_stall = (state != SIdle);
  assign accept   = in_valid && (state == SIdle);
  assign exec_go  = (state == SExec) && (!out_valid || !out_stall);

  assign pid_in_range = (pid_q >= id_t'(1)) && (32'(pid_q) <= 32'(MaxIds));
  assign pid_slot     = slot_t'(pid_q - id_t'(1));
  assign pid_taken    = pid_in_range && marks[pid_slot];

  assign head_in_range = (head_id >= id_t'(1)) && (32'(head_id) <= 32'(MaxIds));
  assign head_id_slot  = slot_t'(head_id - id_t'(1));

  assign alloc_full = (32'(used_count) >= 32'(MaxIds));
  assign do_alloc   = (func_q == FuncAlloc) && !alloc_full;
  assign do_release = (func_q == FuncRelease) && pid_taken;

  always_comb begin
    stat_next    = StatOk;
    granted_next = '0;
    taken_next   = pid_taken;
    case (func_q)
      FuncAlloc: begin
        if (alloc_full) begin
          stat_next = StatNoneFree;
        end else begin
          granted_next = head_id;
          if (pid_in_range && (pid_q == head_id)) begin
            taken_next = 1'b1;
          end
        end
      end
      FuncRelease: begin
        if (pid_taken) begin
          taken_next = 1'b0;
        end else begin
          stat_next = StatBadRelease;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    qreq.rd_en   = accept;
    qreq.rd_addr = head;
    qreq.wr_en   = exec_go && do_release;
    qreq.wr_addr = tail;
    qreq.wr_data = pid_q;
  end

  pidfl_free_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .req     (qreq),
    .rd_data (head_id)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SIdle;
      head       <= '0;
      tail       <= '0;
      marks      <= '0;
      used_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !exec_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        SIdle: begin
          if (accept) begin
            func_q <= func;
            pid_q  <= proc_id;
            state  <= SExec;
          end
        end
        SExec: begin
          if (exec_go) begin
            if (do_alloc) begin
              head       <= next_slot(head);
              used_count <= used_count + CountW'(1);
              if (head_in_range) begin
                marks[head_id_slot] <= 1'b1;
              end
            end
            if (do_release) begin
              tail              <= next_slot(tail);
              marks[pid_slot]   <= 1'b0;
              if (used_count != '0) begin
                used_count <= used_count - CountW'(1);
              end
            end
            out_valid    <= 1'b1;
            granted_id   <= granted_next;
            status       <= stat_next;
            is_taken     <= taken_next;
            in_use_count <= do_alloc ? used_count + CountW'(1)
                          : (do_release && used_count != '0) ? used_count - CountW'(1)
                          : used_count;
            state        <= SIdle;
          end
        end
        default: begin
          state <= SIdle;
        end
      endcase
    end
  end

endmodule

// ===== test/testbench.sv =====
// Testbench for the identifier allocator: directed, exhaustion and random request streams.
`timescale 1ns / 1ps

module testbench;
  import pidfl_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int RandomReqs = 950;
  localparam int ReplyDepth = 16;

  typedef struct {
    id_t        granted;
    status_t    st;
    logic       taken;
    logic [5:0] count;
  } reply_t;

  typedef enum int {StallNone, StallLight, StallHeavy, StallSolid} stall_mode_t;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] func     = 2'd0;
  logic [5:0] proc_id  = 6'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [5:0] granted_id;
  logic [1:0] status;
  logic       is_taken;
  logic [5:0] in_use_count;

  id_t         ring_ids [MaxIds];
  int          ring_head;
  int          ring_tail;
  logic        held [MaxIds];
  int          held_count;
  reply_t      reply_ring [ReplyDepth];
  int          reply_wr    = 0;
  int          reply_rd    = 0;
  reply_t      oldest_reply;
  int          errors      = 0;
  int          burst_left  = 0;
  int          cycle_count = 0;
  int          stall_left  = 0;
  stall_mode_t stall_mode  = StallNone;

  pid_free_list_allocator uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic is_held(id_t id);
    return (id >= 1 && id <= MaxIds) ? held[id - 1] : 1'b0;
  endfunction

  function automatic void reset_pool();
    for (int k = 0; k < MaxIds; k++) begin
      ring_ids[k] = id_t'(k + 1);
      held[k]     = 1'b0;
    end
    ring_head  = 0;
    ring_tail  = 0;
    held_count = 0;
  endfunction

  function automatic reply_t apply_request(func_t f, id_t id);
    reply_t r;
    r.granted = '0;
    r.st      = StatOk;
    case (f)
      FuncAlloc: begin
        if (held_count >= MaxIds) begin
          r.st = StatNoneFree;
        end else begin
          r.granted = ring_ids[ring_head];
          ring_head = (ring_head == MaxIds - 1) ? 0 : ring_head + 1;
          if (r.granted >= 1 && r.granted <= MaxIds) held[r.granted - 1] = 1'b1;
          held_count++;
        end
      end
      FuncRelease: begin
        if (is_held(id)) begin
          ring_ids[ring_tail] = id;
          ring_tail = (ring_tail == MaxIds - 1) ? 0 : ring_tail + 1;
          held[id - 1] = 1'b0;
          held_count--;
        end else begin
          r.st = StatBadRelease;
        end
      end
      default: begin
      end
    endcase
    r.taken = is_held(id);
    r.count = held_count[5:0];
    return r;
  endfunction

  function automatic id_t pick_held();
    id_t id;
    if (held_count == 0) return id_t'($urandom_range(0, 63));
    do begin
      id = id_t'($urandom_range(1, MaxIds));
    end while (!held[id - 1]);
    return id;
  endfunction

  task automatic send_request(func_t f, id_t id);
    in_valid <= 1'b1;
    func     <= f;
    proc_id  <= id;
    do @(posedge clk); while (in_stall);
    reply_ring[reply_wr % ReplyDepth] = apply_request(f, id);
    reply_wr++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (reply_wr != reply_rd) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [5:0] want, logic [5:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic test_directed();
    send_request(FuncQuery, 6'd0);
    send_request(FuncQuery, 6'd63);
    send_request(FuncQuery, 6'd33);
    send_request(FuncRelease, 6'd0);
    send_request(FuncRelease, 6'd33);
    send_request(FuncRelease, 6'd63);
    send_request(FuncRelease, 6'd7);
    send_request(FuncNop, 6'd63);
    send_request(FuncAlloc, 6'd63);
    send_request(FuncQuery, 6'd1);
    send_request(FuncNop, 6'd1);
    send_request(FuncRelease, 6'd1);
    send_request(FuncRelease, 6'd1);
    send_request(FuncAlloc, 6'd0);
    send_request(FuncQuery, 6'd2);
    send_request(FuncQuery, 6'd32);
    send_request(FuncNop, 6'd0);
    send_request(FuncRelease, 6'd2);
    settle();
  endtask

  task automatic test_exhaustion();
    int order [MaxIds];
    int j;
    int t;
    while (held_count < MaxIds) send_request(FuncAlloc, id_t'($urandom_range(0, 63)));
    send_request(FuncAlloc, 6'd0);
    send_request(FuncAlloc, 6'd63);
    send_request(FuncQuery, id_t'(MaxIds));
    send_request(FuncQuery, id_t'(MaxIds + 1));
    settle();
    for (int k = 0; k < MaxIds; k++) order[k] = k + 1;
    for (int k = MaxIds - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (int k = 0; k < MaxIds; k++) send_request(FuncRelease, id_t'(order[k]));
    send_request(FuncRelease, id_t'(order[0]));
    while (held_count < MaxIds / 2) send_request(FuncAlloc, id_t'($urandom_range(0, 63)));
    settle();
  endtask

  task automatic test_random();
    int r;
    int fill_pct;
    fill_pct = 60;
    for (int n = 0; n < RandomReqs; n++) begin
      if (n % 100 == 0) fill_pct = ((n / 100) % 2 == 0) ? 60 : 25;
      r = $urandom_range(0, 99);
      if (r < fill_pct) begin
        send_request(FuncAlloc, id_t'($urandom_range(0, 63)));
      end else if (r < 80) begin
        send_request(FuncRelease, pick_held());
      end else if (r < 85) begin
        send_request(FuncQuery, id_t'($urandom_range(0, 63)));
      end else if (r < 90) begin
        send_request(FuncQuery, id_t'($urandom_range(1, MaxIds)));
      end else if (r < 95) begin
        send_request(FuncRelease, id_t'($urandom_range(0, 63)));
      end else begin
        send_request(FuncNop, id_t'($urandom_range(0, 63)));
      end
    end
    settle();
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = (stall_mode == StallSolid) ? $urandom_range(1, 15) : $urandom_range(10, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
      default:    out_stall <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (reply_wr == reply_rd) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual granted_id %0d status %0d",
                 $time, granted_id, status);
      end else begin
        oldest_reply = reply_ring[reply_rd % ReplyDepth];
        reply_rd++;
        check_field("granted_id", oldest_reply.granted, granted_id);
        check_field("status", 6'(oldest_reply.st), 6'(status));
        check_field("is_taken", 6'(oldest_reply.taken), 6'(is_taken));
        check_field("in_use_count", oldest_reply.count, in_use_count);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    reset_pool();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_exhaustion();
    test_random();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pidfl_pkg.sv
sv/pidfl_free_queue.sv
sv/pid_free_list_allocator.sv
test/testbench.sv
